@@ hw/rtl/cso_pkg.sv @@
// Shared types, constants and tables for the chord stack oscillator.
// Used by cso_ctrl, cso_datapath and chord_stack_oscillator; no dependencies.
package cso_pkg;

  localparam int VOICES        = 6;
  localparam int MORPH_ENTRIES = 64;
  localparam int NUM_INC       = 6;
  localparam int VIDX_W        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = 18 + $clog2(VOICES + 1);

  localparam logic [CFG_IDX_W-1:0] REG_INC0     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 4'd7;

  localparam logic [1:0] WAVE_SAW    = 2'd0;
  localparam logic [1:0] WAVE_TRI    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_SINE   = 2'd3;

  localparam int SQUARE_LEVEL = 26000;
  localparam int CLIP_LIMIT   = 32767;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef logic [64:0][15:0] qsine_t;

  typedef struct packed {
    logic              load;
    logic              ph;
    logic              mul;
    logic              fin;
    logic [VIDX_W-1:0] idx;
  } cso_cmd_t;

  typedef struct packed {
    logic out_busy;
  } cso_stat_t;

  function automatic logic [15:0] quarter_sine(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (longint'(k) * PI_Q30) / 128;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    return 16'((s * 32767 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic qsine_t build_qsine();
    qsine_t q;
    for (int k = 0; k <= 64; k++) begin
      q[k] = quarter_sine(k);
    end
    return q;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  function automatic logic signed [16:0] sine_at(input logic [8:0] i);
    logic [5:0] r;
    logic [6:0] rr;
    r  = i[5:0];
    rr = 7'd64 - {1'b0, r};
    if (i[8]) begin
      return '0;
    end
    case (i[7:6])
      2'd0:    return $signed({1'b0, QSINE[r]});
      2'd1:    return $signed({1'b0, QSINE[rr]});
      2'd2:    return -$signed({1'b0, QSINE[r]});
      default: return -$signed({1'b0, QSINE[rr]});
    endcase
  endfunction

  function automatic logic [7:0] morph(input logic [5:0] i);
    case (i)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: return 8'd255;
      6'd6:  return 8'd214;  6'd7:  return 8'd171;  6'd8:  return 8'd128;
      6'd9:  return 8'd86;   6'd10: return 8'd43;   6'd11: return 8'd43;
      6'd12: return 8'd42;   6'd13: return 8'd85;   6'd14: return 8'd128;
      6'd15: return 8'd170;  6'd16: return 8'd213;  6'd17: return 8'd255;
      6'd18: return 8'd171;  6'd19: return 8'd86;   6'd20: return 8'd0;
      6'd21: return 8'd85;   6'd22: return 8'd170;  6'd23: return 8'd255;
      6'd24: return 8'd171;  6'd25: return 8'd86;   6'd26: return 8'd0;
      6'd27: return 8'd85;   6'd28: return 8'd170;  6'd29: return 8'd255;
      6'd30: return 8'd0;    6'd31: return 8'd255;  6'd32: return 8'd0;
      6'd33: return 8'd255;  6'd34: return 8'd0;    6'd35: return 8'd255;
      6'd36: return 8'd0;    6'd37: return 8'd0;    6'd38: return 8'd0;
      6'd39: return 8'd255;  6'd40: return 8'd255;  6'd41: return 8'd0;
      6'd42: return 8'd0;    6'd43: return 8'd255;  6'd44: return 8'd255;
      6'd45: return 8'd255;  6'd46: return 8'd0;    6'd47: return 8'd0;
      6'd48: return 8'd221;  6'd49: return 8'd127;  6'd50: return 8'd71;
      6'd51: return 8'd8;    6'd52: return 8'd197;  6'd53: return 8'd19;
      6'd54: return 8'd98;   6'd55: return 8'd137;  6'd56: return 8'd55;
      6'd57: return 8'd70;   6'd58: return 8'd122;  6'd59: return 8'd153;
      6'd60: return 8'd50;   6'd61: return 8'd203;  6'd62: return 8'd43;
      default: return 8'd198;
    endcase
  endfunction

endpackage

@@ hw/rtl/cso_ctrl.sv @@
// Sequencer for the chord stack oscillator: walks each voice through a phase state and a multiply state.
// Depends on cso_pkg; drives cso_datapath through cso_cmd_t.
module cso_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cso_pkg::cso_stat_t stat,
  output cso_pkg::cso_cmd_t  cmd
);
  import cso_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PH   = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

  logic [1:0]        state_r, state_nxt;
  logic [VIDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_PH;
        end
      end
      ST_PH: begin
        cmd.ph    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_PH;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

@@ hw/rtl/cso_datapath.sv @@
// Datapath: config registers, per-voice phase and level, waveform, weighting, sum.
// Depends on cso_pkg; sequenced by cso_ctrl.
module cso_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cso_pkg::cso_cmd_t             cmd,
  output cso_pkg::cso_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic [cso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cso_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_sync_first,
  input  logic                          in_sync_second,
  input  logic [14:0]                   in_timbre,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_midpoint_sample,
  output logic signed [15:0]            out_current_sample
);
  import cso_pkg::*;

  logic [31:0] inc_r [NUM_INC];
  logic [1:0]  waveform_r;
  logic [2:0]  active_r;
  logic [31:0] phase_r [VOICES];
  logic [15:0] level_r [VOICES];
  logic signed [15:0] last_r;

  logic        sync_r;
  logic [5:0]  pos_r;
  logic [8:0]  frac_r;

  logic [31:0]        pn_r;
  logic signed [16:0] a_r;
  logic signed [34:0] prod_r;
  logic [15:0]        target_r;
  logic signed [34:0] term_r;
  logic signed [SUM_W-1:0] sum_r;

  logic        out_valid_r;
  logic signed [15:0] mid_r, cur_r;

  // phase stage
  logic [31:0]        p, pn, inc_sel;
  logic               act;
  logic [2:0]         count;
  logic [8:0]         sidx;
  logic signed [16:0] sa, sb;
  logic signed [17:0] diff;
  logic [5:0]         m0, m1;
  logic [15:0]        mx, my;
  logic signed [16:0] dxy;
  logic signed [26:0] tprod, tsum;

  // weighting stage
  logic [16:0]        q;
  logic signed [17:0] t, s, value;
  logic [15:0]        lvl;
  logic signed [17:0] ldiff, lnew;

  // finish
  logic signed [SUM_W-1:0] total;
  logic signed [15:0]      clip;
  logic signed [16:0]      msum;

  assign count   = (32'(active_r) > VOICES) ? 3'(VOICES) : active_r;
  assign act     = 32'(cmd.idx) < 32'(count);
  assign inc_sel = (32'(cmd.idx) < NUM_INC) ? inc_r[3'(cmd.idx)] : '0;
  assign p       = phase_r[cmd.idx];
  assign pn      = sync_r ? '0 : (act ? p + {inc_sel[30:0], 1'b0} : p);
  assign sidx    = {1'b0, pn[31:24]};
  assign sa      = sine_at(sidx);
  assign sb      = sine_at(sidx + 9'd1);
  assign diff    = 18'(sb) - 18'(sa);
  assign m0      = pos_r + 6'(cmd.idx);
  assign m1      = m0 + 6'd1;
  assign mx      = {morph(m0), 8'h00};
  assign my      = {morph(m1), 8'h00};
  assign dxy     = $signed({1'b0, my}) - $signed({1'b0, mx});
  assign tprod   = 27'(dxy * $signed({1'b0, frac_r}));
  assign tsum    = $signed({2'b00, mx, 9'd0}) - $signed({11'd0, mx}) + tprod;

  always_comb begin
    q = pn_r[31:15];
    t = '0;
    s = a_r + 18'(prod_r >>> 16);
    case (waveform_r)
      WAVE_SAW:    value = 18'sd32768 - $signed({2'b00, pn_r[31:16]});
      WAVE_TRI: begin
        if (q > 17'd65536) t = 18'sd32768 - $signed({2'b00, q[15:0]});
        else               t = $signed({1'b0, q}) - 18'sd32768;
        value = (t >>> 1) + (t >>> 3);
      end
      WAVE_SQUARE: value = (pn_r > 32'h8000_0000) ? 18'(SQUARE_LEVEL) : -18'(SQUARE_LEVEL);
      default:     value = (s >>> 1) + (s >>> 3);
    endcase
  end

  assign lvl   = level_r[cmd.idx];
  assign ldiff = $signed({2'b00, target_r}) - $signed({2'b00, lvl});
  assign lnew  = $signed({2'b00, lvl}) + (ldiff >>> 4);

  always_comb begin
    total = sum_r + SUM_W'(term_r >>> 18);
    if (total > SUM_W'(CLIP_LIMIT))       clip = 16'(CLIP_LIMIT);
    else if (total < -SUM_W'(CLIP_LIMIT)) clip = -16'(CLIP_LIMIT);
    else                                   clip = 16'(total);
    msum = 17'(last_r) + 17'(clip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INC; i++) inc_r[i] <= '0;
      waveform_r <= WAVE_SINE;
      active_r   <= 3'd6;
    end else if (cfg_valid) begin
      if (cfg_index < CFG_IDX_W'(NUM_INC))
        inc_r[3'(cfg_index - REG_INC0)] <= cfg_data;
      else if (cfg_index == REG_WAVEFORM)
        waveform_r <= cfg_data[1:0];
      else if (cfg_index == REG_ACTIVE)
        active_r <= cfg_data[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0;
        level_r[i] <= '0;
      end
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ph)  phase_r[cmd.idx] <= pn;
      if (cmd.mul) level_r[cmd.idx] <= lnew[15:0];
      if (cmd.fin) begin
        last_r      <= clip;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sync_r <= in_sync_first | in_sync_second;
      pos_r  <= in_timbre[14:9];
      frac_r <= in_timbre[8:0];
      sum_r  <= '0;
      term_r <= '0;
    end
    if (cmd.ph) begin
      pn_r     <= pn;
      a_r      <= sa;
      prod_r   <= 35'(diff * $signed({1'b0, pn[23:8]}));
      target_r <= act ? tsum[24:9] : '0;
      sum_r    <= sum_r + SUM_W'(term_r >>> 18);
    end
    if (cmd.mul) term_r <= 35'(value * $signed({1'b0, lvl}));
    if (cmd.fin) begin
      cur_r <= clip;
      mid_r <= 16'(msum >>> 1);
    end
  end

  assign stat.out_busy      = out_valid_r & ~out_ready;
  assign out_valid          = out_valid_r;
  assign out_current_sample = cur_r;
  assign out_midpoint_sample = mid_r;

endmodule

@@ hw/rtl/chord_stack_oscillator.sv @@
// Top level of the chord stack oscillator: sequencer plus datapath.
// Depends on cso_pkg, cso_ctrl and cso_datapath.
//
// One request (sync flags and timbre) yields one result pair: the clipped sum of
// up to six weighted voices and its midpoint to the previous sum. The voice loop
// steps each voice through a phase state and then a multiply state, on one shared
// phase/weighting path. The result is registered in the finish state after the
// last voice's multiply state, and the next request can be taken once the
// sequencer is back in idle. The result is registered only once the previous one
// has been taken, so a stalled result delays the next request by the stall.
// Config writes are always ready and take effect the next cycle; write only while
// idle.
module chord_stack_oscillator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cso_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_sync_first,
  input  logic                          in_sync_second,
  input  logic [14:0]                   in_timbre,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_midpoint_sample,
  output logic signed [15:0]            out_current_sample
);
  import cso_pkg::*;

  cso_cmd_t  cmd;
  cso_stat_t stat;

  assign cfg_ready = 1'b1;

  cso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cso_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_sync_first       (in_sync_first),
    .in_sync_second      (in_sync_second),
    .in_timbre           (in_timbre),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_midpoint_sample (out_midpoint_sample),
    .out_current_sample  (out_current_sample)
  );

endmodule

@@ hw/rtl/cso_checker.sv @@
// Port-level checks for chord_stack_oscillator, attached by bind.
// Depends only on the top level's ports.
module cso_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_midpoint_sample,
  input logic signed [15:0] out_current_sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_sample))
    else $error("result changed while stalled");

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_sample != 16'sh8000 && out_midpoint_sample != 16'sh8000)
    else $error("sample outside clip range");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 !$rose(out_valid))
    else $error("result too early");

endmodule

bind chord_stack_oscillator cso_checker u_cso_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_midpoint_sample (out_midpoint_sample),
  .out_current_sample  (out_current_sample)
);
